// ===== design/tsb_pkg.sv =====
`timescale 1ns / 1ps

package tsb_pkg;

  localparam int unsigned BLOCK_W  = 16;
  localparam int unsigned NIB_W    = 4;
  localparam int unsigned NIB_CNT  = BLOCK_W / NIB_W;
  localparam int unsigned ROT_AMT  = 3;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } tsb_op_e;

  typedef enum logic {
    REG_KEY_A = 1'b0,
    REG_KEY_B = 1'b1
  } tsb_reg_e;

  typedef struct packed {
    tsb_op_e              op;
    logic [BLOCK_W-1:0]   blk;
  } tsb_word_t;

  function automatic logic [NIB_W-1:0] sbox_fwd(input logic [NIB_W-1:0] x);
    logic [NIB_W-1:0] y;
    unique case (x)
      4'h0: y = 4'hC;
      4'h1: y = 4'h5;
      4'h2: y = 4'h6;
      4'h3: y = 4'hB;
      4'h4: y = 4'h9;
      4'h5: y = 4'h0;
      4'h6: y = 4'hA;
      4'h7: y = 4'hD;
      4'h8: y = 4'h3;
      4'h9: y = 4'hE;
      4'hA: y = 4'hF;
      4'hB: y = 4'h8;
      4'hC: y = 4'h4;
      4'hD: y = 4'h7;
      4'hE: y = 4'h1;
      4'hF: y = 4'h2;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [NIB_W-1:0] sbox_rev(input logic [NIB_W-1:0] x);
    logic [NIB_W-1:0] y;
    unique case (x)
      4'h0: y = 4'h5;
      4'h1: y = 4'hE;
      4'h2: y = 4'hF;
      4'h3: y = 4'h8;
      4'h4: y = 4'hC;
      4'h5: y = 4'h1;
      4'h6: y = 4'h2;
      4'h7: y = 4'hD;
      4'h8: y = 4'hB;
      4'h9: y = 4'h4;
      4'hA: y = 4'h6;
      4'hB: y = 4'h3;
      4'hC: y = 4'h0;
      4'hD: y = 4'h7;
      4'hE: y = 4'h9;
      4'hF: y = 4'hA;
      default: y = 4'h0;
    endcase
    return y;
  endfunction

  function automatic logic [BLOCK_W-1:0] sub_layer(input logic [BLOCK_W-1:0] v,
                                                    input logic inv);
    logic [BLOCK_W-1:0] res;
    res = '0;
    for (int n = 0; n < NIB_CNT; n++) begin
      res[n*NIB_W +: NIB_W] = inv ? sbox_rev(v[n*NIB_W +: NIB_W])
                                  : sbox_fwd(v[n*NIB_W +: NIB_W]);
    end
    return res;
  endfunction

  function automatic logic [BLOCK_W-1:0] rot_left(input logic [BLOCK_W-1:0] v);
    return {v[BLOCK_W-1-ROT_AMT:0], v[BLOCK_W-1:BLOCK_W-ROT_AMT]};
  endfunction

  function automatic logic [BLOCK_W-1:0] rot_right(input logic [BLOCK_W-1:0] v);
    return {v[ROT_AMT-1:0], v[BLOCK_W-1:ROT_AMT]};
  endfunction

endpackage

// ===== design/toy_spn_block_cipher_16.sv =====
`timescale 1ns / 1ps
// 16-bit toy substitution-permutation cipher, one word in and one word out.
// input channel: in_valid_i with opcode_i (0 encrypt, 1 decrypt) and
// data_block_i; a word is taken when in_valid_i is high and in_stall_o low.
// output channel: out_valid_o with result_block_o; a word leaves when
// out_valid_o is high and out_stall_i low.
// keys: cfg_we_i writes cfg_data_i to key a (index 0) or key b (index 1);
// write keys only while no word is in flight.
// the datapath is a chain of ROUND_COUNT round cells, each a register stage
// doing one full round; an accepted word is registered in each cell in turn
// and out_valid_o rises once it sits in the last cell; throughput is one word
// per cycle while out_stall_i is low.
// each cell holds its word while the next one is full and stalled, so a
// stall at the output backs up one cell at a time; in_stall_o rises only
// once every cell is holding a word.
// reset clears both keys to zero and empties the chain; it needs no
// clearing pass.
module toy_spn_block_cipher_16
  import tsb_pkg::*;
#(
  parameter int unsigned ROUND_COUNT = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [BLOCK_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [BLOCK_W-1:0] data_block_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BLOCK_W-1:0] result_block_o
);

  logic [BLOCK_W-1:0] key_a_q;
  logic [BLOCK_W-1:0] key_b_q;

  logic      valid  [ROUND_COUNT+1];
  logic      ready  [ROUND_COUNT+1];
  tsb_word_t word   [ROUND_COUNT+1];
  logic [ROUND_COUNT-1:0] cell_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_a_q <= '0;
      key_b_q <= '0;
    end else if (cfg_we_i) begin
      unique case (tsb_reg_e'(cfg_idx_i))
        REG_KEY_A: key_a_q <= cfg_data_i;
        REG_KEY_B: key_b_q <= cfg_data_i;
        default:   key_a_q <= key_a_q;
      endcase
    end
  end

  assign valid[0]            = in_valid_i;
  assign word[0].op          = tsb_op_e'(opcode_i);
  assign word[0].blk         = data_block_i;
  assign ready[ROUND_COUNT]  = !out_stall_i;

  for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_cell
    tsb_round_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .key_a_i (key_a_q),
      .key_b_i (key_b_q),
      .valid_i (valid[g]),
      .word_i  (word[g]),
      .ready_o (ready[g]),
      .valid_o (valid[g+1]),
      .word_o  (word[g+1]),
      .ready_i (ready[g+1])
    );
    assign cell_full[g] = valid[g+1];
  end

  assign in_stall_o     = !ready[0];
  assign out_valid_o    = valid[ROUND_COUNT];
  assign result_block_o = word[ROUND_COUNT].blk;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> &cell_full)
    else $error("input stalled with an empty cell in the chain");

  a_no_stall_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output is moving");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> cell_full[0])
    else $error("accepted word not held in the first cell");
`endif

endmodule

// ===== design/tsb_round_cell.sv =====
`timescale 1ns / 1ps

module tsb_round_cell
  import tsb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [BLOCK_W-1:0] key_a_i,
  input  logic [BLOCK_W-1:0] key_b_i,
  input  logic               valid_i,
  input  tsb_word_t          word_i,
  output logic               ready_o,
  output logic               valid_o,
  output tsb_word_t          word_o,
  input  logic               ready_i
);

  logic               valid_q, valid_d;
  tsb_word_t          word_q, word_d;
  logic [BLOCK_W-1:0] enc_blk;
  logic [BLOCK_W-1:0] dec_blk;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    enc_blk = sub_layer(rot_left(word_i.blk ^ key_a_i), 1'b0) ^ key_b_i;
    dec_blk = rot_right(sub_layer(word_i.blk ^ key_b_i, 1'b1)) ^ key_a_i;
  end

  always_comb begin
    valid_d    = ready_o ? valid_i : valid_q;
    word_d     = word_q;
    if (ready_o && valid_i) begin
      word_d.op = word_i.op;
      unique case (word_i.op)
        OP_ENCRYPT: word_d.blk = enc_blk;
        OP_DECRYPT: word_d.blk = dec_blk;
        default:    word_d.blk = enc_blk;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule

// ===== tb/tb_toy_spn_block_cipher_16.sv =====
`timescale 1ns / 1ps

module tb_toy_spn_block_cipher_16
  import tsb_pkg::*;
();

  localparam int ROUNDS = 4;
  localparam int STALL_LIMIT = 2000;
  // nibble n of each table sits at bits [4n+3:4n]
  localparam logic [63:0] FWD_BOX = 64'h2174_8FE3_DA09_B65C;
  localparam logic [63:0] INV_BOX = 64'hA970_364B_D21C_8FE5;

  class cipher_scoreboard;
    logic [BLOCK_W-1:0] key_a;
    logic [BLOCK_W-1:0] key_b;
    logic [BLOCK_W-1:0] expected_q[$];
    int errors;
    int enc_words;
    int dec_words;
    int results_seen;

    function new();
      key_a = '0;
      key_b = '0;
      errors = 0;
      enc_words = 0;
      dec_words = 0;
      results_seen = 0;
    endfunction

    function void set_key(tsb_reg_e idx, logic [BLOCK_W-1:0] value);
      if (idx == REG_KEY_A) key_a = value;
      else key_b = value;
    endfunction

    function logic [BLOCK_W-1:0] substitute(logic [BLOCK_W-1:0] v, logic [63:0] box);
      logic [BLOCK_W-1:0] res;
      res = '0;
      for (int n = 0; n < NIB_CNT; n++)
        res[n*NIB_W +: NIB_W] = box[v[n*NIB_W +: NIB_W]*NIB_W +: NIB_W];
      return res;
    endfunction

    function logic [BLOCK_W-1:0] encrypt_block(logic [BLOCK_W-1:0] blk);
      logic [BLOCK_W-1:0] s;
      s = blk;
      for (int r = 0; r < ROUNDS; r++) begin
        s = s ^ key_a;
        s = (s << ROT_AMT) | (s >> (BLOCK_W - ROT_AMT));
        s = substitute(s, FWD_BOX) ^ key_b;
      end
      return s;
    endfunction

    function logic [BLOCK_W-1:0] decrypt_block(logic [BLOCK_W-1:0] blk);
      logic [BLOCK_W-1:0] s;
      s = blk;
      for (int r = 0; r < ROUNDS; r++) begin
        s = substitute(s ^ key_b, INV_BOX);
        s = (s >> ROT_AMT) | (s << (BLOCK_W - ROT_AMT));
        s = s ^ key_a;
      end
      return s;
    endfunction

    function void note_word(tsb_op_e op, logic [BLOCK_W-1:0] blk);
      if (op == OP_ENCRYPT) begin
        expected_q.push_back(encrypt_block(blk));
        enc_words++;
      end else begin
        expected_q.push_back(decrypt_block(blk));
        dec_words++;
      end
    endfunction

    function void check_word(logic [BLOCK_W-1:0] got);
      logic [BLOCK_W-1:0] want;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result_block %h", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result_block mismatch: expected %h, got %h", want, got);
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic               cfg_idx_i;
  logic [BLOCK_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               opcode_i;
  logic [BLOCK_W-1:0] data_block_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [BLOCK_W-1:0] result_block_o;

  cipher_scoreboard sb;
  bit calm;
  int quiet_cycles;
  int key_settings;
  int round_trips;

  toy_spn_block_cipher_16 #(.ROUND_COUNT(ROUNDS)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .opcode_i(opcode_i),
    .data_block_i(data_block_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_block_o(result_block_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 24);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(result_block_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic send_word(tsb_op_e op, logic [BLOCK_W-1:0] blk);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < 24) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    data_block_i <= blk;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_word(op, blk);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (ROUNDS + 2) @(posedge clk_i);
  endtask

  task automatic write_keys(logic [BLOCK_W-1:0] a, logic [BLOCK_W-1:0] b);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_KEY_A;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_idx_i  <= REG_KEY_B;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    sb.set_key(REG_KEY_A, a);
    sb.set_key(REG_KEY_B, b);
    key_settings++;
  endtask

  task automatic send_both(logic [BLOCK_W-1:0] blk);
    send_word(OP_ENCRYPT, blk);
    send_word(OP_DECRYPT, blk);
  endtask

  initial begin
    logic [BLOCK_W-1:0] edge_blocks[5];
    logic [BLOCK_W-1:0] blk;
    tsb_op_e op;

    sb = new();
    calm = 1'b0;
    key_settings = 1;
    round_trips = 0;
    edge_blocks = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'hA5C3};

    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= REG_KEY_A;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    opcode_i     <= OP_ENCRYPT;
    data_block_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset keys are zero
    foreach (edge_blocks[i]) send_both(edge_blocks[i]);
    drain();

    write_keys(16'hFFFF, 16'h0000);
    send_both(16'h0000);
    send_both(16'hFFFF);
    drain();
    write_keys(16'h0000, 16'hFFFF);
    send_both(16'h0000);
    send_word(OP_DECRYPT, sb.encrypt_block(16'h1234));
    round_trips++;
    drain();
    write_keys(16'hFFFF, 16'hFFFF);
    send_both(16'h7FFE);
    send_word(OP_DECRYPT, sb.encrypt_block(16'hFFFF));
    round_trips++;
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      write_keys(16'($urandom), 16'($urandom));
      calm = (ph == 2);
      for (int k = 0; k < 90; k++) begin
        blk = 16'($urandom);
        if ($urandom_range(99) < 25) begin
          send_word(OP_DECRYPT, sb.encrypt_block(blk));
          round_trips++;
        end else begin
          op = ($urandom_range(1) == 1) ? OP_DECRYPT : OP_ENCRYPT;
          send_word(op, blk);
        end
      end
      drain();
    end
    calm = 1'b0;

    $display("covered %0d encrypt and %0d decrypt words under %0d key settings,",
             sb.enc_words, sb.dec_words, key_settings);
    $display("%0d round trips, %0d results checked, %0d errors",
             round_trips, sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/tsb_pkg.sv
design/tsb_round_cell.sv
design/toy_spn_block_cipher_16.sv
tb/tb_toy_spn_block_cipher_16.sv
